// ===== hdl/utc_timestamp_to_epoch_core_defines.svh =====
// Assertion macros used by the timestamp converter top level.
`ifndef UTC_TIMESTAMP_TO_EPOCH_CORE_DEFINES_SVH
`define UTC_TIMESTAMP_TO_EPOCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define UTC_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons) \
name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
	else $error("same-cycle check failed");
`define UTC_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons) \
name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define UTC_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons)
`define UTC_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons)
`endif

`endif

// ===== hdl/utc_ts_pkg.sv =====
// Types, constants and lookup functions of the timestamp converter.
package utc_ts_pkg;

	localparam int QueueDepth = 2;

	localparam int YearW  = 14;
	localparam int FieldW = 7;
	localparam int EpochW = 38;
	localparam int TodW   = 17;
	localparam int DoyW   = 9;
	localparam int YoeW   = 9;
	localparam int EraW   = 6;
	localparam int DoeW   = 18;
	localparam int DaysW  = 23;

	localparam int Recip400 = 5243;
	localparam int Shift400 = 21;
	localparam int Shift100 = 19;
	localparam int Recip100Small = 41;
	localparam int Shift100Small = 12;
	localparam int DaysPerEra = 146097;
	localparam int EpochDayShift = 719468;
	localparam int SecPerDay = 86400;
	localparam int MinYear = 1970;

	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] Ch0     = 8'h30;
	localparam logic [7:0] Ch9     = 8'h39;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChT     = 8'h54;
	localparam logic [7:0] ChZ     = 8'h5A;

	typedef enum logic [3:0] {
		PH_YEAR,
		PH_MONTH,
		PH_DAY,
		PH_HOUR,
		PH_MINUTE,
		PH_SECOND,
		PH_FRAC_FIRST,
		PH_FRAC,
		PH_ZSEEN
	} phase_t;

	typedef struct packed {
		logic              ok;
		logic [YearW-1:0]  year;
		logic [FieldW-1:0] month;
		logic [FieldW-1:0] day;
		logic [FieldW-1:0] hour;
		logic [FieldW-1:0] minute;
		logic [FieldW-1:0] second;
	} ts_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] sep_of(input phase_t ph);
		case (ph)
			PH_YEAR, PH_MONTH: sep_of = ChMinus;
			PH_DAY:            sep_of = ChT;
			default:           sep_of = ChColon;
		endcase
	endfunction

	function automatic phase_t next_field(input phase_t ph);
		case (ph)
			PH_YEAR:   next_field = PH_MONTH;
			PH_MONTH:  next_field = PH_DAY;
			PH_DAY:    next_field = PH_HOUR;
			PH_HOUR:   next_field = PH_MINUTE;
			default:   next_field = PH_SECOND;
		endcase
	endfunction

	// day of the March-based year on which each month starts
	function automatic logic [DoyW-1:0] month_base(input logic [3:0] m);
		case (m)
			4'd1:    month_base = 9'd306;
			4'd2:    month_base = 9'd337;
			4'd3:    month_base = 9'd0;
			4'd4:    month_base = 9'd31;
			4'd5:    month_base = 9'd61;
			4'd6:    month_base = 9'd92;
			4'd7:    month_base = 9'd122;
			4'd8:    month_base = 9'd153;
			4'd9:    month_base = 9'd184;
			4'd10:   month_base = 9'd214;
			4'd11:   month_base = 9'd245;
			4'd12:   month_base = 9'd275;
			default: month_base = 9'd0;
		endcase
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
			4'd2:                                       month_len = 5'd28;
			default:                                    month_len = 5'd0;
		endcase
	endfunction

endpackage

// ===== hdl/utc_ts_parse.sv =====
// Front end: character parser that builds one field record per text.
module utc_ts_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               push,
	output utc_ts_pkg::ts_rec_t rec
);
	import utc_ts_pkg::*;

	phase_t            phase_q, phase_d;
	logic [2:0]        chars_q, chars_d;
	logic              neg_q, neg_d;
	logic              sign_q, sign_d;
	logic [YearW-1:0]  accum_q, accum_d;
	logic [YearW-1:0]  year_q, year_d;
	logic [FieldW-1:0] month_q, month_d;
	logic [FieldW-1:0] day_q, day_d;
	logic [FieldW-1:0] hour_q, hour_d;
	logic [FieldW-1:0] minute_q, minute_d;
	logic [FieldW-1:0] second_q, second_d;
	logic              failed_q, failed_d;

	logic       is_dig;
	logic       is_sp;
	logic [2:0] fwidth;
	logic       fld_ok;

	always_comb begin
		phase_d  = phase_q;
		chars_d  = chars_q;
		neg_d    = neg_q;
		sign_d   = sign_q;
		accum_d  = accum_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		failed_d = failed_q;
		is_dig   = (ch >= Ch0) && (ch <= Ch9);
		is_sp    = ch inside {ChSpace, [ChTab:ChCr]};
		fwidth   = (phase_q == PH_YEAR) ? 3'd4 : 3'd2;
		fld_ok   = (chars_q > {2'b00, sign_q}) && !(neg_q && (accum_q != '0));
		if (!failed_q) begin
			case (phase_q)
				PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
					if ((chars_q != 3'd0) || !is_sp) begin
						if ((chars_q == 3'd0) && ((ch == ChPlus) || (ch == ChMinus))) begin
							sign_d  = 1'b1;
							neg_d   = (ch == ChMinus);
							chars_d = 3'd1;
						end else if (is_dig && (chars_q < fwidth)) begin
							accum_d = (accum_q << 3) + (accum_q << 1) + {10'd0, ch[3:0]};
							chars_d = chars_q + 3'd1;
						end else if (!fld_ok) begin
							failed_d = 1'b1;
						end else begin
							case (phase_q)
								PH_YEAR:   year_d   = accum_q;
								PH_MONTH:  month_d  = accum_q[FieldW-1:0];
								PH_DAY:    day_d    = accum_q[FieldW-1:0];
								PH_HOUR:   hour_d   = accum_q[FieldW-1:0];
								PH_MINUTE: minute_d = accum_q[FieldW-1:0];
								default:   second_d = accum_q[FieldW-1:0];
							endcase
							if (phase_q == PH_SECOND) begin
								if (ch == ChDot) begin
									phase_d = PH_FRAC_FIRST;
								end else if (ch == ChZ) begin
									phase_d = PH_ZSEEN;
								end else begin
									failed_d = 1'b1;
								end
							end else if (ch == sep_of(phase_q)) begin
								phase_d = next_field(phase_q);
								chars_d = 3'd0;
								neg_d   = 1'b0;
								sign_d  = 1'b0;
								accum_d = '0;
							end else begin
								failed_d = 1'b1;
							end
						end
					end
				end
				PH_FRAC_FIRST: begin
					if (is_dig) begin
						phase_d = PH_FRAC;
					end else begin
						failed_d = 1'b1;
					end
				end
				PH_FRAC: begin
					if (ch == ChZ) begin
						phase_d = PH_ZSEEN;
					end else if (!is_dig) begin
						failed_d = 1'b1;
					end
				end
				default: failed_d = 1'b1;
			endcase
		end
		rec.ok     = !failed_d && (phase_d == PH_ZSEEN);
		rec.year   = year_d;
		rec.month  = month_d;
		rec.day    = day_d;
		rec.hour   = hour_d;
		rec.minute = minute_d;
		rec.second = second_d;
	end

	assign push = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_YEAR;
			chars_q  <= '0;
			neg_q    <= 1'b0;
			sign_q   <= 1'b0;
			accum_q  <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			failed_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				phase_q  <= PH_YEAR;
				chars_q  <= '0;
				neg_q    <= 1'b0;
				sign_q   <= 1'b0;
				accum_q  <= '0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				chars_q  <= chars_d;
				neg_q    <= neg_d;
				sign_q   <= sign_d;
				accum_q  <= accum_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				failed_q <= failed_d;
			end
		end
	end

endmodule

// ===== hdl/utc_ts_queue.sv =====
// Short record queue between the parser and the epoch pipeline.
module utc_ts_queue #(
	parameter int DEPTH = utc_ts_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utc_ts_pkg::ts_rec_t wr_rec,
	input  logic                pop,
	output utc_ts_pkg::ts_rec_t rd_rec,
	output utc_ts_pkg::q_stat_t stat
);
	import utc_ts_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	ts_rec_t         mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/utc_ts_calc.sv =====
// Back end: range checks and days-from-civil epoch pipeline.
module utc_ts_calc (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  utc_ts_pkg::ts_rec_t               in_rec,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_ok,
	output logic [utc_ts_pkg::EpochW-1:0]     out_epoch
);
	import utc_ts_pkg::*;

	logic adv;

	// stage 1
	logic              month_le2;
	logic [YearW-1:0]  yadj;
	logic [26:0]       prod_era;
	logic [26:0]       prod_year;
	logic [TodW-1:0]   tod_c;
	logic              range_ok;
	logic              v_s1, ok_s1;
	logic [YearW-1:0]  yadj_s1, year_s1;
	logic [EraW-1:0]   era_s1, q400_s1;
	logic [7:0]        q100_s1;
	logic [FieldW-1:0] month_s1, day_s1;
	logic [DoyW-1:0]   doy_s1;
	logic [TodW-1:0]   tod_s1;

	// stage 2
	logic [YearW-1:0]  era400;
	logic [YearW-1:0]  yoe_c;
	logic [14:0]       c100x, c400x;
	logic              leap;
	logic [4:0]        limit;
	logic              v_s2, ok_s2;
	logic [YoeW-1:0]   yoe_s2;
	logic [EraW-1:0]   era_s2;
	logic [DoyW-1:0]   doy_s2;
	logic [TodW-1:0]   tod_s2;

	// stage 3
	logic [DoeW-1:0]   yoe365;
	logic [14:0]       yoe41;
	logic [DoeW-1:0]   doe_c;
	logic              v_s3, ok_s3;
	logic [DoeW-1:0]   doe_s3;
	logic [DaysW-1:0]  era146_s3;
	logic [TodW-1:0]   tod_s3;

	// stage 4
	logic              v_s4, ok_s4;
	logic [DaysW-1:0]  days_s4;
	logic [TodW-1:0]   tod_s4;

	// output
	logic [39:0]       secs;
	logic              out_valid_q, out_ok_q;
	logic [EpochW-1:0] out_epoch_q;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && in_valid;

	assign month_le2 = (in_rec.month <= 7'd2);
	assign yadj      = in_rec.year - {13'd0, month_le2};
	assign prod_era  = {13'd0, yadj} * 27'(Recip400);
	assign prod_year = {13'd0, in_rec.year} * 27'(Recip400);
	assign tod_c     = {10'd0, in_rec.hour} * TodW'(3600) + {10'd0, in_rec.minute} * TodW'(60)
		+ {10'd0, in_rec.second};
	assign range_ok  = in_rec.ok && (in_rec.year >= YearW'(MinYear)) && (in_rec.month >= 7'd1)
		&& (in_rec.month <= 7'd12) && (in_rec.hour <= 7'd23) && (in_rec.minute <= 7'd59)
		&& (in_rec.second <= 7'd60) && (in_rec.day >= 7'd1);

	assign era400 = {8'd0, era_s1} * YearW'(400);
	assign yoe_c  = yadj_s1 - era400;
	assign c100x  = {7'd0, q100_s1} * 15'd100;
	assign c400x  = {9'd0, q400_s1} * 15'd400;
	assign leap   = ((year_s1[1:0] == 2'b00) && (c100x != {1'b0, year_s1}))
		|| (c400x == {1'b0, year_s1});
	assign limit  = month_len(month_s1[3:0])
		+ {4'd0, (month_s1 == 7'd2) && leap};

	assign yoe365 = {9'd0, yoe_s2} * DoeW'(365);
	assign yoe41  = {6'd0, yoe_s2} * 15'(Recip100Small);
	assign doe_c  = yoe365 + {11'd0, yoe_s2[YoeW-1:2]}
		- {15'd0, yoe41[Shift100Small +: 3]} + {9'd0, doy_s2};

	assign secs = {17'd0, days_s4} * 40'(SecPerDay) + {23'd0, tod_s4};

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1     <= range_ok;
			yadj_s1   <= yadj;
			year_s1   <= in_rec.year;
			era_s1    <= prod_era[Shift400 +: EraW];
			q400_s1   <= prod_year[Shift400 +: EraW];
			q100_s1   <= prod_year[Shift100 +: 8];
			month_s1  <= in_rec.month;
			day_s1    <= in_rec.day;
			doy_s1    <= month_base(in_rec.month[3:0]) + {2'd0, in_rec.day} - 9'd1;
			tod_s1    <= tod_c;

			ok_s2     <= ok_s1 && (day_s1 <= {2'd0, limit});
			yoe_s2    <= yoe_c[YoeW-1:0];
			era_s2    <= era_s1;
			doy_s2    <= doy_s1;
			tod_s2    <= tod_s1;

			ok_s3     <= ok_s2;
			doe_s3    <= doe_c;
			era146_s3 <= {17'd0, era_s2} * DaysW'(DaysPerEra);
			tod_s3    <= tod_s2;

			ok_s4     <= ok_s3;
			days_s4   <= era146_s3 + {5'd0, doe_s3} - DaysW'(EpochDayShift);
			tod_s4    <= tod_s3;

			out_ok_q    <= ok_s4;
			out_epoch_q <= ok_s4 ? secs[EpochW-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ok    = out_ok_q;
	assign out_epoch = out_epoch_q;

endmodule

// ===== hdl/utc_timestamp_to_epoch_core.sv =====
// Top level: ISO 8601 UTC timestamp text to Unix epoch seconds.
// The block takes one character per clock on the input stream and holds tready high
// except while its record queue is full; a queue of QUEUE_DEPTH records sits between
// the parser and a five-stage epoch pipeline whose last stage is the output register,
// so one text ending per cycle can be absorbed. After the character flagged tlast is taken,
// its record passes through the queue and the pipeline stages to the output register; the
// pipeline advances as a whole whenever its output register is empty or being taken.
// tuser carries the valid flag, tdata the epoch seconds (zero when the text is invalid).
`include "utc_timestamp_to_epoch_core_defines.svh"

module utc_timestamp_to_epoch_core #(
	parameter int QUEUE_DEPTH = utc_ts_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [37:0] epoch_seconds, [39:38] zero
	output logic        m_axis_tuser   // [0] valid_res
);
	import utc_ts_pkg::*;

	logic              take;
	logic              q_push;
	logic              q_pop;
	ts_rec_t           q_wr_rec;
	ts_rec_t           q_rd_rec;
	q_stat_t           q_stat;
	logic [EpochW-1:0] epoch;

	assign s_axis_tready = !q_stat.full;
	assign take          = s_axis_tvalid && s_axis_tready;

	utc_ts_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (s_axis_tdata),
		.last   (s_axis_tlast),
		.push   (q_push),
		.rec    (q_wr_rec)
	);

	utc_ts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_rec (q_wr_rec),
		.pop    (q_pop),
		.rd_rec (q_rd_rec),
		.stat   (q_stat)
	);

	utc_ts_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_stat.empty),
		.in_rec    (q_rd_rec),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ok    (m_axis_tuser),
		.out_epoch (epoch)
	);

	assign m_axis_tdata = {2'b00, epoch};

	`UTC_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, q_push, !q_stat.full)
	`UTC_ASSERT_IMPL(a_stall_only_full, clk, arst_n, !s_axis_tready, q_stat.full)
	`UTC_ASSERT_IMPL(a_push_on_last, clk, arst_n, q_push, s_axis_tvalid && s_axis_tlast)
	`UTC_ASSERT_NEXT(a_pop_frees_slot, clk, arst_n, q_pop && !q_push, !q_stat.full)

endmodule

// ===== tb/utc_timestamp_to_epoch_core_tb.sv =====
// Self-checking testbench: streams timestamp texts through the converter and checks each epoch word.
module utc_timestamp_to_epoch_core_tb;
	import utc_ts_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	typedef struct packed {
		logic              ok;
		logic [EpochW-1:0] secs;
	} epoch_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] ch
	logic        s_axis_tlast = 1'b0;   // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;          // [37:0] epoch_seconds, [39:38] zero
	logic        m_axis_tuser;          // [0] valid_res

	char_word_t  char_q[$];
	epoch_word_t epoch_q[$];
	logic [7:0]  txt[$];
	char_word_t  next_word;
	epoch_word_t want;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned mismatches = 0;
	bit          hold_go = 1'b0;
	bit          sink_hold = 1'b0;
	string       near_chars = "0123456789+-T:.Z";

	logic [7:0] field_seps [5] = '{ChMinus, ChMinus, ChT, ChColon, ChColon};
	int unsigned mdays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	phase_t      cur_phase = PH_YEAR;
	int unsigned fld_len = 0;
	int unsigned fld_val = 0;
	bit          fld_neg = 1'b0;
	bit          fld_signed = 1'b0;
	bit          parse_bad = 1'b0;
	int unsigned yr = 0, mon = 0, dy = 0, hr = 0, mnt = 0, sc = 0;

	utc_timestamp_to_epoch_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic bit is_digit(input logic [7:0] c);
		return c >= Ch0 && c <= Ch9;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == ChSpace || (c >= ChTab && c <= ChCr);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		bit leap;
		if (m < 1 || m > 12) begin
			return 0;
		end
		leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		return mdays[m-1] + ((m == 2 && leap) ? 1 : 0);
	endfunction

	function automatic logic [EpochW-1:0] civil_to_epoch(input int unsigned y, input int unsigned m,
		input int unsigned d, input int unsigned h, input int unsigned mi, input int unsigned s);
		longint unsigned yy, era, yoe, mp, doy, doe, days;
		yy = y - ((m <= 2) ? 1 : 0);
		era = yy / 400;
		yoe = yy - era * 400;
		mp = (m > 2) ? m - 3 : m + 9;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = era * 146097 + doe - 719468;
		return EpochW'(days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + s);
	endfunction

	function automatic bit date_in_range();
		if (yr < MinYear || mon < 1 || mon > 12 || hr > 23 || mnt > 59 || sc > 60) begin
			return 1'b0;
		end
		return dy >= 1 && dy <= days_in_month(yr, mon);
	endfunction

	function automatic void clear_field();
		fld_len = 0;
		fld_val = 0;
		fld_neg = 1'b0;
		fld_signed = 1'b0;
	endfunction

	function automatic bit close_field();
		if (fld_len <= fld_signed) begin
			return 1'b0;
		end
		if (fld_neg && fld_val != 0) begin
			return 1'b0;
		end
		case (cur_phase)
			PH_YEAR:   yr = fld_val;
			PH_MONTH:  mon = fld_val;
			PH_DAY:    dy = fld_val;
			PH_HOUR:   hr = fld_val;
			PH_MINUTE: mnt = fld_val;
			default:   sc = fld_val;
		endcase
		return 1'b1;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		int unsigned width;
		if (parse_bad) begin
			return;
		end
		if (cur_phase <= PH_SECOND) begin
			width = (cur_phase == PH_YEAR) ? 4 : 2;
			if (fld_len == 0 && is_blank(c)) begin
				return;
			end
			if (fld_len == 0 && (c == ChPlus || c == ChMinus)) begin
				fld_signed = 1'b1;
				fld_neg = (c == ChMinus);
				fld_len = 1;
				return;
			end
			if (is_digit(c) && fld_len < width) begin
				fld_val = fld_val * 10 + (c - Ch0);
				fld_len++;
				return;
			end
			if (!close_field()) begin
				parse_bad = 1'b1;
				return;
			end
			if (cur_phase < PH_SECOND) begin
				if (c == field_seps[cur_phase]) begin
					cur_phase = phase_t'(cur_phase + 1);
					clear_field();
				end else begin
					parse_bad = 1'b1;
				end
				return;
			end
			if (c == ChDot) begin
				cur_phase = PH_FRAC_FIRST;
			end else if (c == ChZ) begin
				cur_phase = PH_ZSEEN;
			end else begin
				parse_bad = 1'b1;
			end
			return;
		end
		if (cur_phase == PH_FRAC_FIRST) begin
			if (is_digit(c)) begin
				cur_phase = PH_FRAC;
			end else begin
				parse_bad = 1'b1;
			end
		end else if (cur_phase == PH_FRAC) begin
			if (c == ChZ) begin
				cur_phase = PH_ZSEEN;
			end else if (!is_digit(c)) begin
				parse_bad = 1'b1;
			end
		end else begin
			parse_bad = 1'b1;
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic last);
		epoch_word_t w;
		scan_char(c);
		if (!last) begin
			return;
		end
		w.ok = !parse_bad && cur_phase == PH_ZSEEN && date_in_range();
		w.secs = w.ok ? civil_to_epoch(yr, mon, dy, hr, mnt, sc) : '0;
		epoch_q.push_back(w);
		cur_phase = PH_YEAR;
		clear_field();
		yr = 0;
		mon = 0;
		dy = 0;
		hr = 0;
		mnt = 0;
		sc = 0;
		parse_bad = 1'b0;
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			txt.push_back(s[i]);
		end
	endfunction

	function automatic void emit_text();
		char_word_t w;
		if (txt.size() == 0) begin
			txt.push_back(ChZ);
		end
		foreach (txt[i]) begin
			w.ch = txt[i];
			w.last = (i == txt.size() - 1);
			char_q.push_back(w);
		end
		txt.delete();
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned r;
		r = $urandom_range(5);
		return (r == 5) ? ChSpace : ChTab + r[7:0];
	endfunction

	function automatic void add_field(input int unsigned v, input int unsigned w);
		int unsigned nd, p, d;
		if ($urandom_range(99) < 10) begin
			txt.push_back(blank_char());
		end
		if ($urandom_range(99) < 8) begin
			txt.push_back($urandom_range(1) ? ChMinus : ChPlus);
			w = w - 1;
			v = $urandom_range(1) ? 0 : v % ((w == 3) ? 1000 : 10);
		end
		nd = w;
		if ($urandom_range(99) < 15) begin
			nd = 1;
			p = 10;
			while (nd < w && v >= p) begin
				nd++;
				p = p * 10;
			end
		end
		for (int i = nd; i > 0; i--) begin
			d = 1;
			repeat (i - 1) d = d * 10;
			txt.push_back(Ch0 + 8'((v / d) % 10));
		end
	endfunction

	function automatic void gen_text();
		int unsigned y, mo, d, h, mi, s, lim, n;
		txt.delete();
		if ($urandom_range(99) < 8) begin
			n = $urandom_range(24, 1);
			repeat (n) begin
				if ($urandom_range(1)) begin
					txt.push_back(8'($urandom_range(255)));
				end else begin
					txt.push_back(near_chars.getc($urandom_range(15)));
				end
			end
			return;
		end
		y = ($urandom_range(99) < 85) ? $urandom_range(9999, MinYear) : $urandom_range(MinYear - 1);
		mo = ($urandom_range(99) < 92) ? $urandom_range(12, 1) : $urandom_range(99);
		lim = days_in_month(y, mo);
		if (lim == 0) begin
			lim = 31;
		end
		d = ($urandom_range(99) < 90) ? $urandom_range(lim, 1) : $urandom_range(lim + 1);
		h = ($urandom_range(99) < 92) ? $urandom_range(23) : $urandom_range(99, 24);
		mi = ($urandom_range(99) < 92) ? $urandom_range(59) : $urandom_range(99, 60);
		s = ($urandom_range(99) < 92) ? $urandom_range(60) : $urandom_range(99, 61);
		if ($urandom_range(99) < 5) begin
			s = 60;
		end
		add_field(y, 4);
		txt.push_back(ChMinus);
		add_field(mo, 2);
		txt.push_back(ChMinus);
		add_field(d, 2);
		txt.push_back(ChT);
		add_field(h, 2);
		txt.push_back(ChColon);
		add_field(mi, 2);
		txt.push_back(ChColon);
		add_field(s, 2);
		if ($urandom_range(99) < 30) begin
			txt.push_back(ChDot);
			repeat ($urandom_range(4, 1)) txt.push_back(Ch0 + 8'($urandom_range(9)));
		end
		txt.push_back(ChZ);
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
				1: txt.delete($urandom_range(txt.size() - 1));
				2: begin
					n = $urandom_range(txt.size() - 1, 1);
					while (txt.size() > n) void'(txt.pop_back());
				end
				default: txt.push_back(near_chars.getc($urandom_range(15)));
			endcase
		end
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (char_q.size() != 0 || s_axis_tvalid || epoch_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_char(s_axis_tdata, s_axis_tlast);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (char_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_word = char_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_word.ch;
					s_axis_tlast <= next_word.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (epoch_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, got valid=%0b epoch=%0d", $time,
						m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					want = epoch_q.pop_front();
					if (m_axis_tuser !== want.ok) begin
						$display("%0t: valid flag: expected %0b, got %0b", $time, want.ok,
							m_axis_tuser);
						mismatches++;
					end
					if (m_axis_tdata !== {2'b00, want.secs}) begin
						$display("%0t: epoch: expected %0d, got %0d", $time, want.secs,
							m_axis_tdata);
						mismatches++;
					end
				end
			end
			m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// hold off the output side long enough to back up the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (300) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned src_modes [4];
		int unsigned snk_modes [4];
		src_modes = '{0, 75, 0, 12};
		snk_modes = '{0, 0, 75, 12};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		add_str("1970-01-01T00:00:00Z");
		emit_text();
		add_str("2026-08-21T21:14:51.969Z");
		emit_text();
		add_str("9999-12-31T23:59:60Z");
		emit_text();
		txt.push_back(ChSpace);
		txt.push_back(ChTab);
		add_str("2000-\n2-+9T-0:");
		txt.push_back(8'h0B);
		add_str("-0:\r");
		txt.push_back(8'h0C);
		add_str("5.0Z");
		emit_text();
		add_str("2100-02-29T00:00:00Z");
		emit_text();
		add_str("2000-01-01T00:00:-1Z");
		emit_text();
		add_str("2000-+-01-01T00:00:00Z");
		emit_text();
		add_str("1970");
		txt.push_back(8'h00);
		emit_text();
		add_str("2000-01-01T00:00:00ZZ");
		emit_text();
		add_str("2000-01-01T00:00:00.Z");
		emit_text();
		add_str("1969-12-31T23:59:59Z");
		emit_text();
		txt.push_back(8'hFF);
		emit_text();
		wait_drained();
		for (int m = 0; m < 4; m++) begin
			src_idle_pct = src_modes[m];
			snk_stall_pct = snk_modes[m];
			n = 0;
			while (n < 330) begin
				gen_text();
				n += txt.size();
				emit_text();
			end
			wait_drained();
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_go = 1'b1;
		n = 0;
		while (n < 320) begin
			gen_text();
			n += txt.size();
			emit_text();
		end
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/utc_ts_pkg.sv
hdl/utc_ts_parse.sv
hdl/utc_ts_queue.sv
hdl/utc_ts_calc.sv
hdl/utc_timestamp_to_epoch_core.sv
tb/utc_timestamp_to_epoch_core_tb.sv
